FILE: rtl/eftl_pkg.sv
`timescale 1ns / 1ps

package eftl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int ENTRY_BYTES     = 8;
  localparam int ENTRY_SHIFT     = $clog2(ENTRY_BYTES);

  // Field widths
  localparam int ADDR_W    = 64;
  localparam int OFS_W     = 32;
  localparam int SLOT_IN_W = 10;
  localparam int COUNT_W   = 11;
  localparam int MATCH_W   = 10;
  localparam int RSLOT_W   = 2;

  // Stream words
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 80;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

  // Item kinds carried in tuser
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Continuation word decode
  localparam logic [ADDR_W-1:0] RESUME_WORD_OFS = 64'd4;
  localparam logic [ADDR_W-1:0] ADDR_LOW_MASK   = 64'hf;
  localparam logic [ADDR_W-1:0] SLOT_MASK       = 64'h3;
  localparam int                CLEAR_BIT       = 2;

  function automatic logic [ADDR_W-1:0] sext_ofs(input logic [OFS_W-1:0] v);
    return {{(ADDR_W-OFS_W){v[OFS_W-1]}}, v};
  endfunction

endpackage

FILE: rtl/eftl_ram.sv
`timescale 1ns / 1ps

module eftl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/exception_fixup_table_lookup_core.sv
`timescale 1ns / 1ps

// Fault-entry table with binary-search lookup.
// Input stream s_axis: tuser selects the item kind (0 load an entry, 1 look up
// an address). A load writes one table slot in the cycle it is accepted and
// gives no output word. A lookup searches the first entry_count entries, which
// software must have loaded in ascending absolute fault-address order.
// Output stream m_axis: one word per lookup; tuser is the found flag.
// Configuration: cfg_we/cfg_index/cfg_data write table_base (index 0) or
// entry_count (index 1); write them only while no lookup is in progress.
// Each lookup probe is a RAM read in the probe state followed by the 64-bit
// address add and compare in the check state. One item is in work at a time.
// Reset clears the FSM, output valid and config registers; the table RAM holds
// garbage until each slot is loaded. When m_axis stalls, a finished result
// waits in the search state and the input stays blocked until it is taken.
module exception_fixup_table_lookup_core
  import eftl_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: entry_index[9:0], fault_offset[41:10], resume_offset[73:42],
  //        lookup_address[137:74], zero pad [143:138]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: match_index[9:0], resume_address[73:10], resume_slot[75:74],
  //        clear_second_result[76], zero pad [79:77]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: found
  output logic                  m_axis_tuser,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [ADDR_W-1:0]  table_base;
  logic [COUNT_W-1:0] entry_count;

  // Search registers
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi_ex;
  logic [IDX_W-1:0]  mid;
  logic [ADDR_W-1:0] mid_loc;
  logic [ADDR_W-1:0] key;

  // Input field unpack
  logic [SLOT_IN_W-1:0] in_entry_index;
  logic [OFS_W-1:0]     in_fault_offset;
  logic [OFS_W-1:0]     in_resume_offset;
  logic [ADDR_W-1:0]    in_lookup_address;
  logic                 in_accept;

  assign in_entry_index    = s_axis_tdata[9:0];
  assign in_fault_offset   = s_axis_tdata[41:10];
  assign in_resume_offset  = s_axis_tdata[73:42];
  assign in_lookup_address = s_axis_tdata[137:74];
  assign in_accept         = s_axis_tvalid && s_axis_tready;

  // Probe index and range test
  logic [CNT_W-1:0] mid_calc;
  logic [IDX_W-1:0] mid_calc_idx;
  logic             range_empty;

  assign range_empty  = (lo >= hi_ex);
  assign mid_calc     = lo + ((hi_ex - CNT_W'(1) - lo) >> 1);
  assign mid_calc_idx = IDX_W'(mid_calc);

  // RAM: {resume_offset, fault_offset}
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [2*OFS_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic [2*OFS_W-1:0]     ram_rdata;

  assign ram_we    = in_accept && (s_axis_tuser == ACT_LOAD) &&
                     (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = IDX_W'(in_entry_index);
  assign ram_wdata = {in_resume_offset, in_fault_offset};

  eftl_ram #(
    .WIDTH (2*OFS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mid_calc_idx),
    .rdata (ram_rdata)
  );

  // Probe compare and continuation
  logic [ADDR_W-1:0] probe_addr;
  logic [ADDR_W-1:0] cont_addr;
  logic              probe_hit;
  logic              probe_below;

  assign probe_addr  = mid_loc + sext_ofs(ram_rdata[OFS_W-1:0]);
  assign cont_addr   = mid_loc + RESUME_WORD_OFS + sext_ofs(ram_rdata[2*OFS_W-1:OFS_W]);
  assign probe_hit   = (probe_addr == key);
  assign probe_below = (probe_addr < key);

  // Output handshake
  logic out_free;
  logic emit_miss;
  logic emit_hit;
  logic out_load;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign emit_miss = (state == ST_PROBE) && range_empty;
  assign emit_hit  = (state == ST_CHECK) && probe_hit;
  assign out_load  = (emit_miss || emit_hit) && out_free;
  assign ram_re    = (state == ST_PROBE) && !range_empty;

  assign s_axis_tready = (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser == ACT_LOOKUP)) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!range_empty) begin
          state_next = ST_CHECK;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!probe_hit) begin
          state_next = ST_PROBE;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_base  <= '0;
      entry_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_BASE:  table_base  <= cfg_data;
        CFG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Search range: open on accept, narrow after each miss-compare
  always_ff @(posedge clk) begin
    if (in_accept && (s_axis_tuser == ACT_LOOKUP)) begin
      lo  <= '0;
      key <= in_lookup_address;
      if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
        hi_ex <= CNT_W'(TABLE_DEPTH);
      end else begin
        hi_ex <= CNT_W'(entry_count);
      end
    end else if ((state == ST_CHECK) && !probe_hit) begin
      if (probe_below) begin
        lo <= CNT_W'(mid) + CNT_W'(1);
      end else begin
        hi_ex <= CNT_W'(mid);
      end
    end
  end

  // Latch probe index and entry location alongside the RAM read
  always_ff @(posedge clk) begin
    if (ram_re) begin
      mid     <= mid_calc_idx;
      mid_loc <= table_base + (ADDR_W'(mid_calc_idx) << ENTRY_SHIFT);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (emit_hit) begin
        m_axis_tuser <= 1'b1;
        m_axis_tdata <= {3'b000,
                         cont_addr[CLEAR_BIT],
                         RSLOT_W'(cont_addr & SLOT_MASK),
                         cont_addr & ~ADDR_LOW_MASK,
                         MATCH_W'(mid)};
      end else begin
        m_axis_tuser <= 1'b0;
        m_axis_tdata <= '0;
      end
    end
  end

  // Table writes only happen between lookups, so reads never race them
  assert property (@(posedge clk) disable iff (rst) ram_we |-> (state == ST_IDLE))
    else $error("table write during a search");

  // A compare always works on a non-empty range
  assert property (@(posedge clk) disable iff (rst) (state == ST_CHECK) |-> (lo < hi_ex))
    else $error("compare with empty search range");

  // Each RAM read is followed by its compare
  assert property (@(posedge clk) disable iff (rst) ram_re |=> (state == ST_CHECK))
    else $error("RAM read not followed by compare");

  // Probe index stays inside the open range
  assert property (@(posedge clk) disable iff (rst)
      ram_re |-> ((mid_calc >= lo) && (mid_calc < hi_ex)))
    else $error("probe index outside search range");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import eftl_pkg::*;

  // Loaded region for full-count phases: a full-depth search probes the last
  // entry of the lower half first, so keys at or below it never leave it
  localparam int FILL_DEPTH = TABLE_DEPTH_DEF / 2;

  typedef struct packed {
    logic                 act;
    logic [SLOT_IN_W-1:0] slot;
    logic [OFS_W-1:0]     fault_ofs;
    logic [OFS_W-1:0]     resume_ofs;
    logic [ADDR_W-1:0]    key;
  } fixup_request_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] index;
    logic [ADDR_W-1:0]  resume_addr;
    logic [RSLOT_W-1:0] rslot;
    logic               clear2;
  } fixup_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = ACT_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TABLE_BASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block: registers and offset tables as the block sees them
  logic [ADDR_W-1:0]  tbl_base = '0;
  logic [COUNT_W-1:0] tbl_count = '0;
  logic [OFS_W-1:0]   fault_tab [TABLE_DEPTH_DEF];
  logic [OFS_W-1:0]   resume_tab [TABLE_DEPTH_DEF];
  // Fault offsets as queued so far, used to aim lookup keys
  logic [OFS_W-1:0]   planned_fault [TABLE_DEPTH_DEF];

  fixup_request_t pending_requests [$];
  fixup_result_t  expected_fixups [$];
  fixup_request_t cur_word;
  fixup_result_t  want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;
  logic hold_arm = 1'b0;
  int mismatches = 0;

  exception_fixup_table_lookup_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Binary search over the mirrored table, same probe order as the block
  function automatic fixup_result_t search_fixup(input logic [ADDR_W-1:0] key);
    fixup_result_t     res;
    int                lo;
    int                hi;
    int                mid;
    logic [ADDR_W-1:0] loc;
    logic [ADDR_W-1:0] fault_at;
    logic [ADDR_W-1:0] cont;
    res = '0;
    lo = 0;
    hi = ((tbl_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(tbl_count)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      loc = tbl_base + (ADDR_W'(mid) << ENTRY_SHIFT);
      fault_at = loc + {{(ADDR_W-OFS_W){fault_tab[mid][OFS_W-1]}}, fault_tab[mid]};
      if (fault_at == key) begin
        cont = loc + RESUME_WORD_OFS
             + {{(ADDR_W-OFS_W){resume_tab[mid][OFS_W-1]}}, resume_tab[mid]};
        res.found = 1'b1;
        res.index = mid[MATCH_W-1:0];
        res.resume_addr = cont & ~ADDR_LOW_MASK;
        res.rslot = RSLOT_W'(cont & SLOT_MASK);
        res.clear2 = cont[CLEAR_BIT];
        return res;
      end else if (fault_at < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  // Absolute fault address of a slot under the current base and queued offsets
  function automatic logic [ADDR_W-1:0] planned_addr(input int i);
    return tbl_base + (ADDR_W'(i) << ENTRY_SHIFT)
         + {{(ADDR_W-OFS_W){planned_fault[i][OFS_W-1]}}, planned_fault[i]};
  endfunction

  function automatic void push_load(input int slot, input logic [OFS_W-1:0] f,
                                    input logic [OFS_W-1:0] r);
    fixup_request_t it;
    it.act = ACT_LOAD;
    it.slot = SLOT_IN_W'(slot);
    it.fault_ofs = f;
    it.resume_ofs = r;
    it.key = {$urandom, $urandom};
    planned_fault[slot] = f;
    pending_requests.push_back(it);
  endfunction

  function automatic void push_lookup(input logic [ADDR_W-1:0] key);
    fixup_request_t it;
    it.act = ACT_LOOKUP;
    it.slot = SLOT_IN_W'($urandom);
    it.fault_ofs = $urandom;
    it.resume_ofs = $urandom;
    it.key = key;
    pending_requests.push_back(it);
  endfunction

  function automatic void note_mismatch(input string what, input logic [OUT_DATA_W-1:0] exp_v,
                                        input logic [OUT_DATA_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endfunction

  // Write one register while the block is idle and track it in the mirror
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TABLE_BASE) begin
      tbl_base = val;
    end else begin
      tbl_count = val[COUNT_W-1:0];
    end
  endtask

  // Wait for every queued word to go out and every result to come back
  task automatic drain_and_wait();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_fixups.size() != 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
  endtask

  // Input driver: predict on accept, then offer the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_word.act == ACT_LOAD) begin
          fault_tab[cur_word.slot] = cur_word.fault_ofs;
          resume_tab[cur_word.slot] = cur_word.resume_ofs;
        end else begin
          expected_fixups.push_back(search_fixup(cur_word.key));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, cur_word.key, cur_word.resume_ofs, cur_word.fault_ofs,
                           cur_word.slot};
          s_axis_tuser <= cur_word.act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm) begin
      hold_cnt <= 300;
    end
  end

  // Output ready: stall at random or for the hold-off
  always @(posedge clk) begin
    if (rst || hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_fixups.size() == 0) begin
        note_mismatch("unexpected word", '0, m_axis_tdata);
      end else begin
        want = expected_fixups.pop_front();
        if (m_axis_tuser !== want.found) begin
          note_mismatch("found", OUT_DATA_W'(want.found), OUT_DATA_W'(m_axis_tuser));
        end
        if (m_axis_tdata[9:0] !== want.index) begin
          note_mismatch("match_index", OUT_DATA_W'(want.index), OUT_DATA_W'(m_axis_tdata[9:0]));
        end
        if (m_axis_tdata[73:10] !== want.resume_addr) begin
          note_mismatch("resume_address", OUT_DATA_W'(want.resume_addr),
                        OUT_DATA_W'(m_axis_tdata[73:10]));
        end
        if (m_axis_tdata[75:74] !== want.rslot) begin
          note_mismatch("resume_slot", OUT_DATA_W'(want.rslot),
                        OUT_DATA_W'(m_axis_tdata[75:74]));
        end
        if (m_axis_tdata[76] !== want.clear2) begin
          note_mismatch("clear_second_result", OUT_DATA_W'(want.clear2),
                        OUT_DATA_W'(m_axis_tdata[76]));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] key_cap;
    logic [OFS_W-1:0]  ofs;
    int                n;
    int                n_eff;
    int                n_fill;
    int                n_lookups;
    int                max_step;
    int                roll;
    bit                noise;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table: every lookup misses
    push_lookup('0);
    push_lookup('1);
    // Offset extremes; slots 0 and 1 come out of order
    push_load(0, 32'h8000_0000, 32'h7fff_ffff);
    push_load(1, 32'h7fff_ffff, 32'h8000_0000);
    push_load(2, 32'h0000_0000, 32'hffff_fffc);
    push_load(3, 32'h0000_0010, 32'h0000_000b);
    push_load(1023, 32'hffff_ffff, 32'h0000_0007);
    drain_and_wait();
    write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(2));
    // Unsorted pair: the first probe decides, the second entry is missed
    push_lookup(planned_addr(0));
    push_lookup(planned_addr(1));
    drain_and_wait();
    // Base near the top: entry locations wrap through zero
    write_reg(CFG_TABLE_BASE, 64'hffff_ffff_ffff_fff8);
    write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(4));
    push_lookup(planned_addr(2));
    push_lookup(planned_addr(3));
    push_lookup(planned_addr(0));

    for (int ph = 0; ph < 10; ph++) begin
      drain_and_wait();
      case (ph % 4)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 71;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 71;
        end
        default: begin
          send_idle_pct <= 25;
          recv_stall_pct <= 25;
        end
      endcase
      case (ph)
        0, 9: base = '0;
        1: base = '1;
        4: base = 64'h8000_0000_0000_0000;
        default: base = {$urandom, $urandom};
      endcase
      noise = (ph == 5 || ph == 8);
      if (ph == 2) begin
        n = TABLE_DEPTH_DEF;
      end else if (ph == 3) begin
        n = (1 << COUNT_W) - 1;
      end else if (ph == 7) begin
        n = 1;
      end else if (noise) begin
        n = $urandom_range(1, FILL_DEPTH);
      end else begin
        n = $urandom_range(2, 24);
      end
      n_eff = (n > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : n;
      n_fill = (n_eff > FILL_DEPTH) ? FILL_DEPTH : n_eff;
      n_lookups = (ph == 2) ? 40 : (ph == 3) ? 24 : noise ? 40 : 25;

      // Keep the full table's base when only the count grows past the depth
      if (ph != 3) begin
        write_reg(CFG_TABLE_BASE, base);
      end
      write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(n));

      // Load an ascending table: each absolute address a random step above the last
      if (!noise && ph != 3) begin
        max_step = (ph == 2) ? 16 : (1 << $urandom_range(3, 20));
        ofs = 32'hc000_0000 + OFS_W'($urandom_range(0, 1 << 20));
        for (int i = 0; i < n_fill; i++) begin
          push_load(i, ofs, $urandom);
          ofs = ofs + OFS_W'($urandom_range(1, max_step)) - OFS_W'(ENTRY_BYTES);
        end
      end

      // Hold the output off while the input keeps offering words
      if (ph == 4) begin
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end

      for (int k = 0; k < n_lookups; k++) begin
        // Pause the sender mid-phase until all results are back
        if (ph == 6 && k == n_lookups / 2) begin
          drain_and_wait();
        end
        roll = $urandom_range(99);
        if (noise && roll < 40) begin
          push_load($urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom, $urandom);
        end else if (!noise && roll < 10 && n_eff < TABLE_DEPTH_DEF) begin
          push_load($urandom_range(n_eff, TABLE_DEPTH_DEF - 1), $urandom, $urandom);
        end else begin
          roll = $urandom_range(99);
          if (roll < 60) begin
            key = planned_addr($urandom_range(0, n_fill - 1));
          end else if (roll < 75) begin
            key = planned_addr($urandom_range(0, n_fill - 1))
                + ($urandom_range(1) ? 64'd1 : '1);
          end else if (roll < 82) begin
            key = $urandom_range(1) ? '0 : '1;
          end else begin
            key = {$urandom, $urandom};
          end
          // Keep full-count searches inside the loaded lower half
          if (n_eff > FILL_DEPTH) begin
            key_cap = planned_addr(FILL_DEPTH - 1);
            if (key > key_cap) begin
              key = key_cap;
            end
          end
          push_lookup(key);
        end
      end
    end

    drain_and_wait();
    if (mismatches == 0 && expected_fixups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
